// ----- hw/rtl/hhtr_pkg.sv -----
// Package for the heading-hold turn-rate block: shared types, fixed-point
// constants and the CORDIC arctangent table.
// Depends on nothing; hhtr_vec_stage and the top level import it.
`default_nettype none

package hhtr_pkg;

   // Widths of the vectoring datapath.
   localparam int CW         = 36;   // CORDIC x and y, signed
   localparam int ZW         = 27;   // accumulated angle, signed degrees Q16
   localparam int SQRT_STEPS = 16;   // one root bit per stage

   // Reciprocal of 45 for exact floor division of values below 2^23.
   localparam logic [23:0] RECIP45     = 24'd11930465;
   localparam int          RECIP_SHIFT = 29;

   // Angles in degrees Q16.
   localparam logic [25:0] DEG90  = 26'd5898240;
   localparam logic [25:0] DEG180 = 26'd11796480;
   localparam logic [25:0] DEG360 = 26'd23592960;

   // Gyro units are 1/64 degree.
   localparam logic signed [31:0] FULL_TURN = 32'sd23040;
   localparam logic signed [16:0] HALF_TURN = 17'sd11520;
   localparam logic signed [16:0] FULL_TURN17 = 17'sd23040;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_ANGLE_HIGH  = 3'd0,
      REG_ANGLE_LOW   = 3'd1,
      REG_RATE_HIGH   = 3'd2,
      REG_RATE_LOW    = 3'd3,
      REG_SCALE_SPEED = 3'd4,
      REG_SPEED_Y     = 3'd5,
      REG_DEADBAND    = 3'd6
   } hhtr_reg_type;

   // Reset values of the registers.
   localparam logic [15:0] RST_ANGLE_HIGH = 16'd22938;
   localparam logic [15:0] RST_ANGLE_LOW  = 16'd328;
   localparam logic [15:0] RST_RATE_HIGH  = 16'd29491;
   localparam logic [15:0] RST_RATE_LOW   = 16'd328;
   localparam logic [15:0] RST_DEADBAND   = 16'd3277;

   // One item as it moves through the CORDIC and square-root stages.
   typedef struct packed {
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic signed [ZW-1:0] z;
      logic [31:0]          n_sh;   // radicand, consumed two bits per stage
      logic [17:0]          rem;
      logic [15:0]          root;
      logic signed [15:0]   x;
      logic signed [15:0]   y;
      logic signed [15:0]   hred;   // gyro heading after reduction
      logic                 rev;
   } hhtr_vec_type;

   // atan(2^-i) in degrees Q16.
   function automatic logic [21:0] hhtr_atan(input int idx);
      logic [21:0] v;
      case (idx)
         0:       v = 22'd2949120;
         1:       v = 22'd1740967;
         2:       v = 22'd919879;
         3:       v = 22'd466945;
         4:       v = 22'd234379;
         5:       v = 22'd117304;
         6:       v = 22'd58666;
         7:       v = 22'd29335;
         8:       v = 22'd14668;
         9:       v = 22'd7334;
         10:      v = 22'd3667;
         11:      v = 22'd1833;
         12:      v = 22'd917;
         13:      v = 22'd458;
         14:      v = 22'd229;
         15:      v = 22'd115;
         16:      v = 22'd57;
         17:      v = 22'd29;
         18:      v = 22'd14;
         19:      v = 22'd7;
         20:      v = 22'd4;
         21:      v = 22'd2;
         22:      v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hhtr_vec_stage.sv -----
// One vectoring register stage: a CORDIC micro-rotation if IDX<CORDIC_STEPS,
// an integer square-root bit if IDX<SQRT_STEPS. Depends on hhtr_pkg.
`default_nettype none

module hhtr_vec_stage import hhtr_pkg::*; #(
   parameter int IDX          = 0,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         adv,
   input  wire logic         valid_d,
   input  wire hhtr_vec_type vec_d,
   output logic              valid_ff,
   output hhtr_vec_type      vec_ff
);

   logic signed [CW-1:0] cx_d;
   logic signed [CW-1:0] cy_d;
   logic signed [ZW-1:0] ang;
   logic [19:0]          rem_w;
   logic [19:0]          trial;
   logic                 fits;
   hhtr_vec_type         vec_in;

   assign cx_d  = vec_d.cx;
   assign cy_d  = vec_d.cy;
   assign ang   = signed'({{(ZW-22){1'b0}}, hhtr_atan(IDX)});
   assign rem_w = {vec_d.rem, vec_d.n_sh[31:30]};
   assign trial = {2'b00, vec_d.root, 2'b01};
   assign fits  = rem_w >= trial;

   // Rotate toward the x axis and take the next root bit.
   always_comb begin
      vec_in = vec_d;
      if (IDX < CORDIC_STEPS) begin
         if (cy_d > 0) begin
            vec_in.cx = cx_d + (cy_d >>> IDX);
            vec_in.cy = cy_d - (cx_d >>> IDX);
            vec_in.z  = vec_d.z + ang;
         end else begin
            vec_in.cx = cx_d - (cy_d >>> IDX);
            vec_in.cy = cy_d + (cx_d >>> IDX);
            vec_in.z  = vec_d.z - ang;
         end
      end
      if (IDX < SQRT_STEPS) begin
         vec_in.n_sh = {vec_d.n_sh[29:0], 2'b00};
         if (fits) begin
            vec_in.rem  = 18'(rem_w - trial);
            vec_in.root = {vec_d.root[14:0], 1'b1};
         end else begin
            vec_in.rem  = rem_w[17:0];
            vec_in.root = {vec_d.root[14:0], 1'b0};
         end
      end
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_d;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vec_ff <= vec_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/hhtr_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage, with a
// side-band word carried alongside. Needs the quotient to fit NUM_W-DEN_W bits.
// Depends on nothing.
`default_nettype none

module hhtr_div #(
   parameter int NUM_W  = 32,
   parameter int DEN_W  = 16,
   parameter int SIDE_W = 19
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      adv,
   input  wire logic                      valid_d,
   input  wire logic [NUM_W-1:0]          num_d,
   input  wire logic [DEN_W-1:0]          den_d,
   input  wire logic [SIDE_W-1:0]         side_d,
   output logic                           valid_q,
   output logic [NUM_W-DEN_W-1:0]         quo_q,
   output logic [SIDE_W-1:0]              side_q
);

   localparam int Q_W = NUM_W - DEN_W;

   logic              valid_ff [Q_W];
   logic [DEN_W:0]    rem_ff   [Q_W];
   logic [Q_W-1:0]    low_ff   [Q_W];
   logic [Q_W-1:0]    quo_ff   [Q_W];
   logic [DEN_W-1:0]  den_ff   [Q_W];
   logic [SIDE_W-1:0] side_ff  [Q_W];

   for (genvar s = 0; s < Q_W; s++) begin : g_step
      logic              vp;
      logic [DEN_W:0]    rp;
      logic [Q_W-1:0]    lp;
      logic [Q_W-1:0]    qp;
      logic [DEN_W-1:0]  dp;
      logic [SIDE_W-1:0] sp;
      logic [DEN_W+1:0]  t;
      logic              ge;
      logic [DEN_W:0]    rem_in;

      // Stage source: the ports for the first stage, else the stage before.
      if (s == 0) begin : g_first
         assign vp = valid_d;
         assign rp = {1'b0, num_d[NUM_W-1:Q_W]};
         assign lp = num_d[Q_W-1:0];
         assign qp = '0;
         assign dp = den_d;
         assign sp = side_d;
      end else begin : g_next
         assign vp = valid_ff[s-1];
         assign rp = rem_ff[s-1];
         assign lp = low_ff[s-1];
         assign qp = quo_ff[s-1];
         assign dp = den_ff[s-1];
         assign sp = side_ff[s-1];
      end

      // Shift in one dividend bit and try to subtract the divisor.
      assign t      = {rp, lp[Q_W-1]};
      assign ge     = t >= {2'b00, dp};
      assign rem_in = ge ? (DEN_W+1)'(t - {2'b00, dp}) : t[DEN_W:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= vp;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= rem_in;
            low_ff[s]  <= {lp[Q_W-2:0], 1'b0};
            quo_ff[s]  <= {qp[Q_W-2:0], ge};
            den_ff[s]  <= dp;
            side_ff[s] <= sp;
         end
      end
   end

   assign valid_q = valid_ff[Q_W-1];
   assign quo_q   = quo_ff[Q_W-1];
   assign side_q  = side_ff[Q_W-1];

endmodule

`default_nettype wire

// ----- hw/rtl/heading_hold_turn_rate_top.sv -----
// Heading-hold turn-rate block, top level.
// Uses hhtr_pkg, hhtr_vec_stage (CORDIC and square root) and hhtr_div.
//
// Each item on the req_ channel carries a stick sample, a gyro heading and a
// reverse flag; each produces exactly one item on the rsp_ channel with the
// drive speed and the turn rate. Registers are written through csr_ with a
// write enable, a register index and data; write them only while no item is
// in flight.
// Stages: CORDIC_STEPS or 16 stages, whichever is more, for the vectoring
// pipeline, 16 stages for the rate divider and 11 further register stages.
// Throughput: one item per cycle while the output does not stall, set by the
// fully pipelined CORDIC, root and divider stages.
// The whole pipeline advances together: when rsp_tready is low while a
// result is shown, every stage holds and req_tready drops; no item is lost
// or repeated. Synchronous reset empties the pipeline and restores the
// register reset values.
`default_nettype none

module heading_hold_turn_rate_top import hhtr_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: stick_x[15:0], stick_y[31:16], gyro_angle[63:32], reverse[64]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,
   // rsp_tdata: drive_speed[16:0], turn_cmd[33:17]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_wen,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [15:0] csr_wdata
);

   localparam int VEC_STAGES = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

   logic adv;

   // Configuration registers.
   logic [15:0] angle_high_ff, angle_low_ff, rate_high_ff, rate_low_ff, deadband_ff;
   logic        scale_ff, speed_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_high_ff <= RST_ANGLE_HIGH;
         angle_low_ff  <= RST_ANGLE_LOW;
         rate_high_ff  <= RST_RATE_HIGH;
         rate_low_ff   <= RST_RATE_LOW;
         scale_ff      <= 1'b0;
         speed_y_ff    <= 1'b0;
         deadband_ff   <= RST_DEADBAND;
      end else if (csr_wen) begin
         case (hhtr_reg_type'(csr_addr))
            REG_ANGLE_HIGH:  angle_high_ff <= csr_wdata;
            REG_ANGLE_LOW:   angle_low_ff  <= csr_wdata;
            REG_RATE_HIGH:   rate_high_ff  <= csr_wdata;
            REG_RATE_LOW:    rate_low_ff   <= csr_wdata;
            REG_SCALE_SPEED: scale_ff      <= csr_wdata[0];
            REG_SPEED_Y:     speed_y_ff    <= csr_wdata[0];
            REG_DEADBAND:    deadband_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The pipeline moves whenever the output register is free or drained.
   logic rsp_valid_ff;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // Stage F1: squares, gyro magnitude and its reciprocal product.
   logic signed [15:0] x_i, y_i;
   logic signed [31:0] h_i;
   logic [31:0]        h_abs;
   logic               f1_valid_ff, f1_rev_ff, f1_hneg_ff, f1_big_ff;
   logic signed [15:0] f1_x_ff, f1_y_ff, f1_h16_ff;
   logic [8:0]         f1_low9_ff;
   logic [22:0]        f1_v_ff;
   logic [46:0]        f1_prod_ff;
   logic [30:0]        f1_xx_ff, f1_yy_ff;
   logic signed [31:0] xx_s, yy_s;

   assign x_i   = req_tdata[15:0];
   assign y_i   = req_tdata[31:16];
   assign h_i   = req_tdata[63:32];
   assign h_abs = h_i[31] ? (~h_i + 32'd1) : h_i;
   assign xx_s  = x_i * x_i;
   assign yy_s  = y_i * y_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_x_ff    <= x_i;
         f1_y_ff    <= y_i;
         f1_h16_ff  <= h_i[15:0];
         f1_hneg_ff <= h_i[31];
         f1_big_ff  <= (h_i > FULL_TURN) || (h_i < -FULL_TURN);
         f1_low9_ff <= h_abs[8:0];
         f1_v_ff    <= h_abs[31:9];
         f1_prod_ff <= {24'd0, h_abs[31:9]} * {23'd0, RECIP45};
         f1_xx_ff   <= xx_s[30:0];
         f1_yy_ff   <= yy_s[30:0];
         f1_rev_ff  <= req_tdata[64];
      end
   end

   // Stage F2: finish the heading remainder and load the vectoring pipeline.
   logic [17:0]        q45;
   logic [23:0]        q45x;
   logic [23:0]        r45;
   logic [15:0]        rem16;
   logic signed [15:0] hred;
   logic [16:0]        ax, ay;
   hhtr_vec_type       f2_in;
   logic               f2_valid_ff;
   hhtr_vec_type       f2_vec_ff;

   assign q45   = f1_prod_ff[46:RECIP_SHIFT];
   assign q45x  = ({6'd0, q45} << 5) + ({6'd0, q45} << 3) + ({6'd0, q45} << 2)
                  + {6'd0, q45};
   assign r45   = {1'b0, f1_v_ff} - q45x;
   assign rem16 = {1'b0, r45[5:0], f1_low9_ff};
   assign hred  = f1_big_ff ? (f1_hneg_ff ? -rem16 : rem16) : f1_h16_ff;
   assign ax    = f1_x_ff[15] ? 17'(-{f1_x_ff[15], f1_x_ff}) : {1'b0, f1_x_ff};
   assign ay    = f1_y_ff[15] ? 17'(-{f1_y_ff[15], f1_y_ff}) : {1'b0, f1_y_ff};

   always_comb begin
      f2_in.cx   = signed'({{(CW-33){1'b0}}, ay, 16'd0});
      f2_in.cy   = signed'({{(CW-33){1'b0}}, ax, 16'd0});
      f2_in.z    = '0;
      f2_in.n_sh = {1'b0, f1_xx_ff} + {1'b0, f1_yy_ff};
      f2_in.rem  = '0;
      f2_in.root = '0;
      f2_in.x    = f1_x_ff;
      f2_in.y    = f1_y_ff;
      f2_in.hred = hred;
      f2_in.rev  = f1_rev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else if (adv) begin
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f2_vec_ff <= f2_in;
      end
   end

   // Vectoring pipeline: bearing by CORDIC and speed by square root.
   logic         vec_valid [VEC_STAGES+1];
   hhtr_vec_type vec_data  [VEC_STAGES+1];

   assign vec_valid[0] = f2_valid_ff;
   assign vec_data[0]  = f2_vec_ff;

   for (genvar g = 0; g < VEC_STAGES; g++) begin : g_vec
      hhtr_vec_stage #(
         .IDX          (g),
         .CORDIC_STEPS (CORDIC_STEPS)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .valid_d  (vec_valid[g]),
         .vec_d    (vec_data[g]),
         .valid_ff (vec_valid[g+1]),
         .vec_ff   (vec_data[g+1])
      );
   end

   // Stage P1: place the bearing in its quadrant, offset the heading.
   hhtr_vec_type       vd;
   logic signed [ZW-1:0] zv;
   logic [25:0]        zc, brg, brg_w;
   logic signed [16:0] hsum, hlift;
   logic               xpos, ypos, yle0;
   logic               p1_valid_ff;
   logic [25:0]        p1_bearing_ff, p1_head_ff;
   logic signed [16:0] p1_speed_ff;

   assign vd   = vec_data[VEC_STAGES];
   assign zv   = vd.z;
   assign xpos = !vd.x[15];
   assign ypos = !vd.y[15];
   assign yle0 = vd.y[15] || (vd.y == 16'sd0);
   assign zc   = (zv < 0) ? 26'd0 : ((zv > signed'({1'b0, DEG90})) ? DEG90 : zv[25:0]);

   always_comb begin
      if (xpos && ypos) begin
         brg = zc;
      end else if (xpos) begin
         brg = DEG180 - zc;
      end else if (yle0) begin
         brg = DEG180 + zc;
      end else begin
         brg = DEG360 - zc;
      end
      brg_w = (brg >= DEG360) ? (brg - DEG360) : brg;
   end

   assign hsum  = {vd.hred[15], vd.hred} + (vd.rev ? HALF_TURN : 17'sd0);
   assign hlift = (hsum < 0) ? (hsum + FULL_TURN17) : hsum;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= vec_valid[VEC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_bearing_ff <= brg_w;
         p1_head_ff    <= {hlift[15:0], 10'd0};
         p1_speed_ff   <= speed_y_ff ? {vd.y[15], vd.y} : {1'b0, vd.root};
      end
   end

   // Stage P2: heading error wrapped into plus or minus 180 degrees.
   logic signed [26:0] diff_raw, diff_w;
   logic               p2_valid_ff;
   logic signed [26:0] p2_diff_ff;
   logic signed [16:0] p2_speed_ff;

   assign diff_raw = signed'({1'b0, p1_head_ff}) - signed'({1'b0, p1_bearing_ff});

   always_comb begin
      if (diff_raw > signed'({1'b0, DEG180})) begin
         diff_w = diff_raw - signed'({1'b0, DEG360});
      end else if (diff_raw < -signed'({1'b0, DEG180})) begin
         diff_w = diff_raw + signed'({1'b0, DEG360});
      end else begin
         diff_w = diff_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_diff_ff  <= diff_w;
         p2_speed_ff <= p1_speed_ff;
      end
   end

   // Stage P3: |error| / 360 as a shift by 3 and a reciprocal product for 45.
   logic [26:0]        dabs;
   logic               p3_valid_ff, p3_dpos_ff;
   logic [44:0]        p3_prod_ff;
   logic signed [16:0] p3_speed_ff;

   assign dabs = p2_diff_ff[26] ? 27'(-p2_diff_ff) : p2_diff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (adv) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_prod_ff  <= {24'd0, dabs[23:3]} * {21'd0, RECIP45};
         p3_dpos_ff  <= p2_diff_ff > 0;
         p3_speed_ff <= p2_speed_ff;
      end
   end

   // Stage P4: clamp the normalized error, high clamp first.
   logic [15:0]        mag;
   logic               p4_valid_ff, p4_dpos_ff;
   logic [15:0]        p4_mag_ff;
   logic signed [16:0] p4_speed_ff;

   assign mag = p3_prod_ff[RECIP_SHIFT+15:RECIP_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else if (adv) begin
         p4_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (mag >= angle_high_ff) begin
            p4_mag_ff <= angle_high_ff;
         end else if (mag <= angle_low_ff) begin
            p4_mag_ff <= angle_low_ff;
         end else begin
            p4_mag_ff <= mag;
         end
         p4_dpos_ff  <= p3_dpos_ff;
         p4_speed_ff <= p3_speed_ff;
      end
   end

   // Stage P5: numerator of the linear map.
   logic signed [16:0] d1, d2;
   logic               p5_valid_ff, p5_dpos_ff;
   logic signed [33:0] p5_num_ff;
   logic signed [16:0] p5_speed_ff;

   assign d1 = signed'({1'b0, p4_mag_ff}) - signed'({1'b0, angle_low_ff});
   assign d2 = signed'({1'b0, rate_high_ff}) - signed'({1'b0, rate_low_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_valid_ff <= 1'b0;
      end else if (adv) begin
         p5_valid_ff <= p4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p5_num_ff   <= d1 * d2;
         p5_dpos_ff  <= p4_dpos_ff;
         p5_speed_ff <= p4_speed_ff;
      end
   end

   // Stage P6: magnitudes and quotient sign for the divider.
   logic signed [16:0] den_s;
   logic [33:0]        num_abs;
   logic               p6_valid_ff;
   logic [31:0]        p6_num_ff;
   logic [15:0]        p6_den_ff;
   logic [18:0]        p6_side_ff;

   assign den_s   = signed'({1'b0, angle_high_ff}) - signed'({1'b0, angle_low_ff});
   assign num_abs = p5_num_ff[33] ? 34'(-p5_num_ff) : p5_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p6_valid_ff <= 1'b0;
      end else if (adv) begin
         p6_valid_ff <= p5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p6_num_ff  <= num_abs[31:0];
         p6_den_ff  <= den_s[16] ? 16'(-den_s) : den_s[15:0];
         p6_side_ff <= {p5_num_ff[33] ^ den_s[16], p5_dpos_ff, p5_speed_ff};
      end
   end

   // Rate divider.
   logic        div_valid;
   logic [15:0] div_quo;
   logic [18:0] div_side;

   hhtr_div #(
      .NUM_W  (32),
      .DEN_W  (16),
      .SIDE_W (19)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .valid_d (p6_valid_ff),
      .num_d   (p6_num_ff),
      .den_d   (p6_den_ff),
      .side_d  (p6_side_ff),
      .valid_q (div_valid),
      .quo_q   (div_quo),
      .side_q  (div_side)
   );

   // Stage P7: signed quotient plus the low rate, or the low rate alone when the angle limits are equal.
   logic signed [17:0] qs;
   logic               p7_valid_ff, p7_dpos_ff;
   logic signed [17:0] p7_rate_ff;
   logic signed [16:0] p7_speed_ff;

   assign qs = div_side[18] ? -signed'({2'b00, div_quo}) : signed'({2'b00, div_quo});

   always_ff @(posedge clock) begin
      if (reset) begin
         p7_valid_ff <= 1'b0;
      end else if (adv) begin
         p7_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p7_rate_ff  <= (angle_high_ff == angle_low_ff) ? signed'({2'b00, rate_low_ff})
                        : qs + signed'({2'b00, rate_low_ff});
         p7_dpos_ff  <= div_side[17];
         p7_speed_ff <= div_side[16:0];
      end
   end

   // Stage P8: product of rate and speed.
   logic               p8_valid_ff, p8_dpos_ff;
   logic signed [34:0] p8_prod_ff;
   logic signed [17:0] p8_rate_ff;
   logic signed [16:0] p8_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p8_valid_ff <= 1'b0;
      end else if (adv) begin
         p8_valid_ff <= p7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p8_prod_ff  <= p7_rate_ff * p7_speed_ff;
         p8_rate_ff  <= p7_rate_ff;
         p8_dpos_ff  <= p7_dpos_ff;
         p8_speed_ff <= p7_speed_ff;
      end
   end

   // Stage P9: scale, sign, deadband and saturation into the output register.
   logic signed [20:0] sc, sgn, fin;
   logic [16:0]        spd_abs;
   logic signed [16:0] rsp_speed_ff, rsp_rate_ff;

   assign spd_abs = p8_speed_ff[16] ? 17'(-p8_speed_ff) : p8_speed_ff;

   always_comb begin
      sc  = scale_ff ? 21'(p8_prod_ff >>> 15) : 21'(p8_rate_ff);
      sgn = p8_dpos_ff ? -sc : sc;
      if (spd_abs < {1'b0, deadband_ff}) begin
         fin = '0;
      end else if (sgn > 21'sd65535) begin
         fin = 21'sd65535;
      end else if (sgn < -21'sd65536) begin
         fin = -21'sd65536;
      end else begin
         fin = sgn;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= p8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_speed_ff <= p8_speed_ff;
         rsp_rate_ff  <= fin[16:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_rate_ff, rsp_speed_ff};

   // Checks on the delivered item against the live register settings.
   logic [16:0] out_speed_abs, out_rate_abs, rate_bound;

   assign out_speed_abs = rsp_speed_ff[16] ? 17'(-rsp_speed_ff) : rsp_speed_ff;
   assign out_rate_abs  = rsp_rate_ff[16] ? 17'(-rsp_rate_ff) : rsp_rate_ff;
   assign rate_bound    = (rate_high_ff > rate_low_ff) ? {1'b0, rate_high_ff}
                          : {1'b0, rate_low_ff};

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_deadband: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (out_speed_abs < {1'b0, deadband_ff}) |-> rsp_rate_ff == 17'sd0)
      else $error("turn rate not zero inside speed deadband");

   a_rate_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !scale_ff |-> out_rate_abs <= rate_bound)
      else $error("unscaled turn rate beyond the rate limits");

   a_magnitude_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !speed_y_ff |-> !rsp_speed_ff[16])
      else $error("stick magnitude came out negative");

endmodule

`default_nettype wire
